// ----- design/number_to_segment_lcd_waveform_macros.svh -----
// ----------------------------------------------------------------------------
// number_to_segment_lcd_waveform_macros
// Assertion macros shared by the LCD waveform encoder. All sample on aclk
// and are off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_SEGMENT_LCD_WAVEFORM_MACROS_SVH
`define NUMBER_TO_SEGMENT_LCD_WAVEFORM_MACROS_SVH

// same-cycle implication
`define NSLCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nslcd_pkg.sv -----
// ----------------------------------------------------------------------------
// nslcd_pkg
// Constants, segment table and frontplane maps of the LCD waveform encoder.
// ----------------------------------------------------------------------------
package nslcd_pkg;

    localparam int MAX_DIGITS      = 4;
    localparam int DIGIT_COUNT_DEF = 4;
    localparam int VAL_W           = 14;   // holds up to 9999
    localparam int PLACE_W         = 2;    // indexes MAX_DIGITS places
    localparam int DATA_W          = 32;

    typedef logic [3:0] digit_t;
    typedef logic [3:0] nibble_t;
    typedef logic [1:0] phase_t;

    // frontplane of each segment, bit s = segment a..g
    localparam logic [6:0] MAP_PIN_NORMAL = 7'b0000111;
    localparam logic [6:0] MAP_PIN_ROT    = 7'b0111000;

    localparam phase_t MAP_PHASE_NORMAL [0:6] = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd3, 2'd2};
    localparam phase_t MAP_PHASE_ROT    [0:6] = '{2'd0, 2'd1, 2'd3, 2'd3, 2'd2, 2'd1, 2'd2};

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    // bit 0 = a ... bit 6 = g
    function automatic logic [6:0] seg_of_digit(input digit_t d);
        logic [6:0] seg;
        unique case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // returns {frontplane 1, frontplane 0} nibbles of one digit
    function automatic logic [7:0] encode_digit(input digit_t d, input logic upside);
        logic [6:0] seg;
        nibble_t    fp0;
        nibble_t    fp1;
        logic       pin;
        phase_t     ph;
        seg = seg_of_digit(d);
        fp0 = '0;
        fp1 = '0;
        for (int s = 0; s < 7; s++) begin
            pin = upside ? MAP_PIN_ROT[s] : MAP_PIN_NORMAL[s];
            ph  = upside ? MAP_PHASE_ROT[s] : MAP_PHASE_NORMAL[s];
            if (seg[s]) begin
                if (pin) fp1[ph] = 1'b1;
                else     fp0[ph] = 1'b1;
            end
        end
        return {fp1, fp0};
    endfunction

endpackage

// ----- design/number_to_segment_lcd_waveform.sv -----
// ----------------------------------------------------------------------------
// number_to_segment_lcd_waveform
// Clamps a number to the display range, splits it into decimal digits,
// blanks leading zeros and encodes the digits into frontplane phase nibbles.
// ----------------------------------------------------------------------------
//
//  channel | direction | word contents
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | tdata[31:0] number
//  m_      | out       | tdata pin0..pin7 phases (4 bits each), tuser saturated
//  cfg_    | in        | data[0] upside_down (segment map select)
//
// One word per cycle while m_tready is high, through four register stages
// (clamp, /100, /10, encode); a word taken on s_ passes through each in turn to m_.
// Each stage holds its own valid bit and stalls only if it is full and the
// stage after it cannot take its word, so bubbles close up under m_tready low.
// aresetn (sync, active low) empties the pipeline and clears upside_down.
// upside_down is read by the encode stage; writes are taken in any cycle.
// ----------------------------------------------------------------------------

`include "number_to_segment_lcd_waveform_macros.svh"

module number_to_segment_lcd_waveform #(
    parameter int DIGIT_COUNT = nslcd_pkg::DIGIT_COUNT_DEF   // 1..4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] number

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [3:0] pin0 .. [31:28] pin7 phases
    output logic [0:0]  m_tuser,    // [0] saturated

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data    // [0] upside_down
);

    localparam int VAL_W   = nslcd_pkg::VAL_W;
    localparam int PLACE_W = nslcd_pkg::PLACE_W;
    localparam int NDIG    = nslcd_pkg::MAX_DIGITS;
    localparam logic [31:0]      LIMIT     = nslcd_pkg::pow10(DIGIT_COUNT);
    localparam logic [VAL_W-1:0] LIMIT_MAX = VAL_W'(LIMIT - 32'd1);

    // ---------------- configuration ----------------
    logic upside_down_reg, upside_down_next;

    assign cfg_ready = 1'b1;
    always_comb begin
        upside_down_next = upside_down_reg;
        if (cfg_valid) upside_down_next = cfg_data[0];
    end

    // ---------------- stage handshakes ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_tvalid_reg;
    logic rdy1, rdy2, rdy3, rdy_out;

    assign rdy_out  = !m_tvalid_reg || m_tready;
    assign rdy3     = !s3_valid_reg || rdy_out;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;

    // ---------------- stage 1: clamp ----------------
    logic [VAL_W-1:0] s1_val_reg, s1_val_next;
    logic             s1_sat_reg, s1_sat_next;

    always_comb begin
        s1_sat_next = s_tdata >= LIMIT;
        s1_val_next = s1_sat_next ? LIMIT_MAX : s_tdata[VAL_W-1:0];
    end

    // ---------------- stage 2: split by 100 ----------------
    // val/100 as (val * 5243) >> 19, exact for val below 10000
    logic [26:0]      s2_prod;
    logic [6:0]       s2_q_reg, s2_q_next;
    logic [6:0]       s2_r_reg, s2_r_next;
    logic [VAL_W-1:0] s2_rem;
    logic             s2_sat_reg;

    always_comb begin
        s2_prod   = 27'(s1_val_reg) * 27'd5243;
        s2_q_next = s2_prod[25:19];
        s2_rem    = s1_val_reg - VAL_W'(s2_q_next) * VAL_W'(7'd100);
        s2_r_next = s2_rem[6:0];
    end

    // ---------------- stage 3: split by 10 ----------------
    // x/10 as (x * 205) >> 11, exact for x below 100
    nslcd_pkg::digit_t s3_dig_reg  [NDIG];   // indexed by decimal place
    nslcd_pkg::digit_t s3_dig_next [NDIG];
    logic              s3_sat_reg;
    logic [14:0]       s3_tq, s3_tr;
    logic [6:0]        s3_lq, s3_lr;

    always_comb begin
        s3_tq = 15'(s2_q_reg) * 15'd205;
        s3_tr = 15'(s2_r_reg) * 15'd205;
        s3_lq = s2_q_reg - 7'(s3_tq[14:11]) * 7'd10;
        s3_lr = s2_r_reg - 7'(s3_tr[14:11]) * 7'd10;
        s3_dig_next[3] = s3_tq[14:11];
        s3_dig_next[2] = s3_lq[3:0];
        s3_dig_next[1] = s3_tr[14:11];
        s3_dig_next[0] = s3_lr[3:0];
    end

    // ---------------- stage 4: blank and encode ----------------
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg;

    always_comb begin
        logic              shown;
        nslcd_pkg::digit_t d;
        shown        = 1'b0;
        d            = '0;
        m_tdata_next = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (i < DIGIT_COUNT) begin
                // position 0 is the most significant shown place
                d = s3_dig_reg[PLACE_W'(DIGIT_COUNT - 1 - i)];
                if (d != 4'd0 || i == DIGIT_COUNT - 1) shown = 1'b1;
                if (shown) begin
                    m_tdata_next[8*i +: 8] = nslcd_pkg::encode_digit(d, upside_down_reg);
                end
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upside_down_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            upside_down_reg <= upside_down_next;
            if (rdy1)    s1_valid_reg <= s_tvalid;
            if (rdy2)    s2_valid_reg <= s1_valid_reg;
            if (rdy3)    s3_valid_reg <= s2_valid_reg;
            if (rdy_out) m_tvalid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_val_reg <= s1_val_next;
            s1_sat_reg <= s1_sat_next;
        end
        if (rdy2) begin
            s2_q_reg   <= s2_q_next;
            s2_r_reg   <= s2_r_next;
            s2_sat_reg <= s1_sat_reg;
        end
        if (rdy3) begin
            s3_dig_reg <= s3_dig_next;
            s3_sat_reg <= s2_sat_reg;
        end
        if (rdy_out) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= s3_sat_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------- assertions ----------------
    `NSLCD_ASSERT_IMP(a_clamp, s1_valid_reg && s1_sat_reg, s1_val_reg == LIMIT_MAX, "clamp value wrong")
    `NSLCD_ASSERT_IMP(a_split100, s2_valid_reg, s2_q_reg < 7'd100 && s2_r_reg < 7'd100, "split by 100 out of range")
    `NSLCD_ASSERT_IMP(a_digits, s3_valid_reg, s3_dig_reg[0] <= 4'd9 && s3_dig_reg[1] <= 4'd9 && s3_dig_reg[2] <= 4'd9 && s3_dig_reg[3] <= 4'd9, "digit above nine")
    `NSLCD_ASSERT_IMP(a_last_shown, m_tvalid_reg, m_tdata_reg[8*(DIGIT_COUNT-1) +: 8] != 8'd0, "last digit blank")
    `NSLCD_ASSERT_IMP(a_full_stall, !s_tready, s1_valid_reg && s2_valid_reg && s3_valid_reg && m_tvalid_reg, "input stalled with a bubble")
    `NSLCD_ASSERT_NEXT(a_take, s_tvalid && s_tready, s1_valid_reg, "accepted word lost")

endmodule
